// ----- sv/ring_window_moving_average_top_defines.svh -----
// Assertion helpers used by the checker file of this block.
`ifndef RING_WINDOW_MOVING_AVERAGE_TOP_DEFINES_SVH
`define RING_WINDOW_MOVING_AVERAGE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RWMA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rwma check failed");

// Consequent must hold in the cycle after the antecedent.
`define RWMA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rwma check failed");

`endif

// ----- sv/rwma_pkg.sv -----
`default_nettype none
package rwma_pkg;

  // Ring geometry.
  localparam int WINDOW_MAX = 256;
  localparam int SLOT_W     = $clog2(WINDOW_MAX);
  localparam int COUNT_W    = SLOT_W + 1;

  // Sample and accumulator widths; the total holds WINDOW_MAX full-scale samples.
  localparam int SAMPLE_W   = 32;
  localparam int TOTAL_W    = SAMPLE_W + SLOT_W;

  // Serial divider: one quotient bit per step over the whole total.
  localparam int DIV_STEPS  = TOTAL_W;
  localparam int STEP_W     = $clog2(DIV_STEPS + 1);

  // Register port.
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;
  localparam int REG_IDX_W  = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = '0;
  localparam logic [COUNT_W-1:0]   WINDOW_RESET      = COUNT_W'(WINDOW_MAX);

  // Result word: mean, oldest, count, padded to whole bytes.
  localparam int RES_BITS   = 2 * SAMPLE_W + COUNT_W;
  localparam int OUT_W      = ((RES_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_OLDEST,
    ST_DIVIDE,
    ST_OUTPUT
  } state_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
  } ring_rd_t;

  typedef struct packed {
    logic                en;
    logic [SLOT_W-1:0]   addr;
    logic [SAMPLE_W-1:0] data;
  } ring_wr_t;

endpackage
`default_nettype wire

// ----- sv/rwma_ring.sv -----
`default_nettype none
module rwma_ring (
  input  logic                          clk,
  input  rwma_pkg::ring_wr_t            wr,
  input  rwma_pkg::ring_rd_t            rd,
  output logic [rwma_pkg::SAMPLE_W-1:0] rd_data
);
  import rwma_pkg::*;

  logic [SAMPLE_W-1:0] mem [WINDOW_MAX];

  // Single write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule
`default_nettype wire

// ----- sv/rwma_div.sv -----
`default_nettype none
module rwma_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rwma_pkg::TOTAL_W-1:0]  dividend,
  input  logic [rwma_pkg::COUNT_W-1:0]  divisor,
  output logic                          done,
  output logic [rwma_pkg::SAMPLE_W-1:0] quotient
);
  import rwma_pkg::*;

  logic [TOTAL_W-1:0]  dq;
  logic [COUNT_W-1:0]  rem;
  logic [COUNT_W-1:0]  dvs;
  logic                neg;
  logic                running;
  logic [STEP_W-1:0]   step;
  logic [COUNT_W:0]    rem_sh;
  logic [COUNT_W:0]    rem_dif;
  logic                fits;
  logic [COUNT_W-1:0]  rem_next;

  // One restoring step: shift in the next dividend bit and try the divisor.
  always_comb begin
    rem_sh   = {rem, dq[TOTAL_W-1]};
    rem_dif  = rem_sh - {1'b0, dvs};
    fits     = rem_sh >= {1'b0, dvs};
    rem_next = fits ? rem_dif[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
  end

  // Control: step counter and the completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= running && (step == STEP_W'(1));
      if (start) begin
        running <= 1'b1;
        step    <= STEP_W'(DIV_STEPS);
      end else if (running) begin
        step <= step - STEP_W'(1);
        if (step == STEP_W'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  // Datapath: the dividend register fills with quotient bits from the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend[TOTAL_W-1] ? (~dividend + TOTAL_W'(1)) : dividend;
      neg <= dividend[TOTAL_W-1];
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      dq  <= {dq[TOTAL_W-2:0], fits};
      rem <= rem_next;
    end
  end

  // Signed result truncated toward zero, low word only.
  assign quotient = neg ? (~dq[SAMPLE_W-1:0] + SAMPLE_W'(1)) : dq[SAMPLE_W-1:0];

endmodule
`default_nettype wire

// ----- sv/ring_window_moving_average_top.sv -----
// Moving average over a ring of the last window_length signed Q16.16 samples
// (1 to 256, reset 256, written over the register port at byte address 0;
// zero acts as 1 and values above 256 as 256, and every write empties the
// ring). Each input word yields one result word holding the mean of the held
// samples truncated toward zero, the oldest held sample and the count held.
// Each item passes through states that read the slot being replaced, write
// the new sample and read the oldest one; a 40-step serial divider then
// produces one quotient bit per cycle from the 40-bit exact running total,
// a wait state sees the divider finish and an output state loads the output
// register. The input is not ready from the time a word is accepted until
// its result word becomes valid, and the next word can be taken in that same
// cycle. The ring needs no clearing pass: a fill count keeps unwritten
// entries from ever being used. A finished result waits in the output
// register, and the next word is taken while it waits; a result that finishes
// while the one before it still waits holds the block until that one is taken.
`default_nettype none
module ring_window_moving_average_top (
  input  logic                          clk,
  input  logic                          rst,
  // Register port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rwma_pkg::ADDR_W-1:0]   paddr,
  input  logic [rwma_pkg::DATA_W-1:0]   pwdata,
  output logic [rwma_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // Input stream.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [rwma_pkg::SAMPLE_W-1:0] s_tdata,  // [31:0] sample
  // Output stream.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rwma_pkg::OUT_W-1:0]    m_tdata   // [31:0] mean_value, [63:32] oldest_value,
                                                  // [72:64] samples_held, rest zero
);
  import rwma_pkg::*;

  state_t              state;
  state_t              state_next;
  logic [COUNT_W-1:0]  window_length;
  logic [COUNT_W-1:0]  eff_len;
  logic [SLOT_W-1:0]   write_slot;
  logic [COUNT_W-1:0]  fill_level;
  logic [TOTAL_W-1:0]  running_total;
  logic [SAMPLE_W-1:0] sample_r;
  logic                cfg_wr;
  logic                ring_full;
  logic [COUNT_W-1:0]  slot_inc;
  logic [SLOT_W-1:0]   slot_adv;
  ring_rd_t            rd;
  ring_wr_t            wr;
  logic [SAMPLE_W-1:0] rd_data;
  logic                div_start;
  logic                div_done;
  logic [SAMPLE_W-1:0] quotient;
  logic                load_out;

  // Register port decode.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
               && (paddr[ADDR_W-1:2] == REG_WINDOW_LENGTH);
  assign prdata = (paddr[ADDR_W-1:2] == REG_WINDOW_LENGTH) ? DATA_W'(window_length) : '0;

  // Window length clamped to the supported range.
  always_comb begin
    if (window_length == '0) begin
      eff_len = COUNT_W'(1);
    end else if (window_length > COUNT_W'(WINDOW_MAX)) begin
      eff_len = COUNT_W'(WINDOW_MAX);
    end else begin
      eff_len = window_length;
    end
  end

  // Ring position bookkeeping.
  assign ring_full = fill_level >= eff_len;
  assign slot_inc  = {1'b0, write_slot} + COUNT_W'(1);
  assign slot_adv  = (slot_inc >= eff_len) ? '0 : slot_inc[SLOT_W-1:0];

  // Sequencer: next state and the strobes to memory, divider and output.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    rd         = '0;
    wr         = '0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        rd.en      = 1'b1;
        rd.addr    = write_slot;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        wr.en      = 1'b1;
        wr.addr    = write_slot;
        wr.data    = sample_r;
        state_next = ST_OLDEST;
      end
      ST_OLDEST: begin
        rd.en      = 1'b1;
        rd.addr    = (fill_level < eff_len) ? '0 : write_slot;
        div_start  = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers and the running state of the ring.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      window_length <= WINDOW_RESET;
      write_slot    <= '0;
      fill_level    <= '0;
      running_total <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        window_length <= pwdata[COUNT_W-1:0];
        write_slot    <= '0;
        fill_level    <= '0;
        running_total <= '0;
      end else if (state == ST_READ) begin
        running_total <= running_total
                       + {{(TOTAL_W-SAMPLE_W){sample_r[SAMPLE_W-1]}}, sample_r};
      end else if (state == ST_UPDATE) begin
        if (ring_full) begin
          running_total <= running_total
                         - {{(TOTAL_W-SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data};
        end else begin
          fill_level <= fill_level + COUNT_W'(1);
        end
        write_slot <= slot_adv;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      sample_r <= s_tdata;
    end
    if (load_out) begin
      m_tdata <= {{(OUT_W-RES_BITS){1'b0}}, fill_level, rd_data, quotient};
    end
  end

  rwma_ring u_ring (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  rwma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (running_total),
    .divisor  (fill_level),
    .done     (div_done),
    .quotient (quotient)
  );

endmodule
`default_nettype wire

// ----- sv/rwma_checker.sv -----
`default_nettype none
`include "ring_window_moving_average_top_defines.svh"
module rwma_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [rwma_pkg::OUT_W-1:0] m_tdata
);
  import rwma_pkg::*;

  // Once a word is taken the block works on it and takes no other.
  `RWMA_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)

  // A result never appears in the cycle right after a word is taken.
  `RWMA_ASSERT_NEXT(a_no_instant_result, clk, rst, s_tvalid && s_tready, !$rose(m_tvalid))

  // Every result holds at least one and at most a full window of samples.
  `RWMA_ASSERT_SAME(a_count_range, clk, rst, m_tvalid, (m_tdata[2*SAMPLE_W+COUNT_W-1:2*SAMPLE_W] != '0) && (m_tdata[2*SAMPLE_W+COUNT_W-1:2*SAMPLE_W] <= COUNT_W'(WINDOW_MAX)))

  // A stalled result word holds.
  `RWMA_ASSERT_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind ring_window_moving_average_top rwma_checker u_rwma_checker (.*);
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
module testbench;
  import rwma_pkg::*;

  // Sample patterns used by the stimulus phases.
  typedef enum int {
    MIX_ANY,
    MIX_EXTREME,
    MIX_SMALLVAL,
    MIX_HIGH,
    MIX_LOW
  } sample_mix_t;

  // One result word as the block should produce it.
  typedef struct {
    logic signed [SAMPLE_W-1:0] mean;
    logic signed [SAMPLE_W-1:0] oldest;
    logic [COUNT_W-1:0]         held;
  } average_word_t;

  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 1'b1;

  logic                clk;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata = '0;   // [31:0] sample
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_W-1:0]    m_tdata;        // [31:0] mean_value, [63:32] oldest_value,
                                       // [72:64] samples_held, rest zero

  // Averaging state of the predictor.
  logic signed [SAMPLE_W-1:0] ring_store [WINDOW_MAX];
  logic [COUNT_W-1:0]         win_reg = WINDOW_RESET;
  int                         ring_slot = 0;
  int                         ring_fill = 0;
  longint                     ring_total = 0;

  logic [SAMPLE_W-1:0] samples_pending [$];
  average_word_t       averages_due [$];
  int                  mismatch_count = 0;

  int   send_gap_max = 4;
  int   recv_gap_max = 4;
  int   send_wait = 0;
  int   recv_wait = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  ring_window_moving_average_top dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Appends one sample word to the sender's queue.
  function automatic void queue_sample(input logic [SAMPLE_W-1:0] value);
    samples_pending.insert(samples_pending.size(), value);
  endfunction

  // A window write also empties the ring.
  function automatic void window_written(input logic [DATA_W-1:0] value);
    win_reg = value[COUNT_W-1:0];
    ring_slot = 0;
    ring_fill = 0;
    ring_total = 0;
  endfunction

  // Adds one sample to the ring and queues the mean, oldest and count it gives.
  function automatic void predict_average(input logic signed [SAMPLE_W-1:0] smp);
    int            len;
    longint        quot;
    average_word_t w;
    if (win_reg == 0) len = 1;
    else if (win_reg > WINDOW_MAX) len = WINDOW_MAX;
    else len = win_reg;
    if (ring_slot >= len) ring_slot = 0;
    if (ring_fill > len) ring_fill = len;
    if (ring_fill >= len) ring_total -= ring_store[ring_slot];
    else ring_fill++;
    ring_store[ring_slot] = smp;
    ring_total += smp;
    ring_slot = (ring_slot + 1 >= len) ? 0 : ring_slot + 1;
    quot = ring_total / longint'(ring_fill);
    w.mean = quot[SAMPLE_W-1:0];
    // Before the ring is full the oldest sample sits in the first slot.
    w.oldest = (ring_fill < len) ? ring_store[0] : ring_store[ring_slot];
    w.held = COUNT_W'(ring_fill);
    averages_due.insert(averages_due.size(), w);
  endfunction

  task automatic check_average(input logic [OUT_W-1:0] word);
    average_word_t due;
    if (averages_due.size() == 0) begin
      report_mismatch($sformatf("result word with nothing due: %h", word));
      return;
    end
    due = averages_due.pop_front();
    if (word[SAMPLE_W-1:0] !== due.mean)
      report_mismatch($sformatf("mean_value %h, expected %h", word[SAMPLE_W-1:0], due.mean));
    if (word[2*SAMPLE_W-1:SAMPLE_W] !== due.oldest)
      report_mismatch($sformatf("oldest_value %h, expected %h",
                                word[2*SAMPLE_W-1:SAMPLE_W], due.oldest));
    if (word[RES_BITS-1:2*SAMPLE_W] !== due.held)
      report_mismatch($sformatf("samples_held %0d, expected %0d",
                                word[RES_BITS-1:2*SAMPLE_W], due.held));
    if (word[OUT_W-1:RES_BITS] !== '0)
      report_mismatch($sformatf("padding bits not zero: %h", word[OUT_W-1:RES_BITS]));
  endtask

  function automatic logic [SAMPLE_W-1:0] draw_sample(input sample_mix_t mix);
    logic [SAMPLE_W-1:0] v;
    case (mix)
      MIX_EXTREME: begin
        case ($urandom_range(0, 4))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          3: v = 32'hFFFF_FFFF;
          default: v = 32'h0000_0001;
        endcase
      end
      MIX_SMALLVAL: v = $urandom_range(0, 2048) - 1024;
      MIX_HIGH: v = 32'h7F00_0000 | ($urandom() & 32'h00FF_FFFF);
      MIX_LOW: v = 32'h8000_0000 | ($urandom() & 32'h00FF_FFFF);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Sample driver: one word per handshake, with a drawn gap after each word.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (s_tvalid && s_tready) predict_average(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          s_tvalid <= 1'b0;
        end else if (samples_pending.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= samples_pending.pop_front();
          send_wait <= $urandom_range(0, send_gap_max);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver stall, started once by the stimulus and counted here.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: checks each accepted word and draws a stall after it.
  always @(posedge clk) begin : result_monitor
    int stall;
    if (rst) begin
      m_tready <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (m_tvalid && m_tready) check_average(m_tdata);
      if (hold_left != 0) begin
        m_tready <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        stall = $urandom_range(0, recv_gap_max);
        recv_wait <= stall;
        m_tready <= (stall == 0);
      end else if (recv_wait != 0) begin
        recv_wait <= recv_wait - 1;
        m_tready <= (recv_wait == 1);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_WINDOW_LENGTH) window_written(value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_window_readback();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {REG_WINDOW_LENGTH, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== DATA_W'(win_reg))
      report_mismatch($sformatf("window_length read %h, expected %h", prdata, win_reg));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Waits until every queued sample has been sent and every result due has been taken.
  task automatic wait_all_results();
    while (samples_pending.size() != 0 || s_tvalid || averages_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input logic [DATA_W-1:0] win_word, input int count,
                           input sample_mix_t mix, input bit send_busy, input bit recv_busy);
    wait_all_results();
    apb_write(REG_WINDOW_LENGTH, win_word);
    check_window_readback();
    send_gap_max = send_busy ? 4 : 0;
    recv_gap_max = recv_busy ? 4 : 0;
    repeat (count) queue_sample(draw_sample(mix));
  endtask

  initial begin : stimulus
    int                  random_items;
    int                  count;
    logic [DATA_W-1:0]   win_word;
    sample_mix_t         mix;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    check_window_readback();

    // Reset window of 256: full-scale and sign-boundary samples.
    queue_sample(32'h7FFF_FFFF);
    queue_sample(32'h8000_0000);
    queue_sample(32'hFFFF_FFFF);
    queue_sample(32'h0000_0001);
    queue_sample(32'h0000_0000);
    queue_sample(32'h7FFF_FFFF);
    queue_sample(32'h7FFF_FFFF);

    // A window of one is full at once.
    wait_all_results();
    apb_write(REG_WINDOW_LENGTH, 32'd1);
    check_window_readback();
    queue_sample(32'h8000_0000);
    queue_sample(32'h7FFF_FFFF);
    queue_sample(32'hFFFF_FFFB);

    // A zero window behaves as a window of one.
    wait_all_results();
    apb_write(REG_WINDOW_LENGTH, 32'd0);
    check_window_readback();
    queue_sample(32'h0001_0000);
    queue_sample(32'h8000_0000);

    // Window of three: a negative mean truncates toward zero, then the ring wraps
    // across a write to an unmapped address, which must leave the ring alone.
    wait_all_results();
    apb_write(REG_WINDOW_LENGTH, 32'd3);
    check_window_readback();
    queue_sample(32'hFFFF_FFFF);
    queue_sample(32'hFFFF_FFFE);
    wait_all_results();
    apb_write(REG_UNMAPPED, 32'd1);
    check_window_readback();
    queue_sample(32'h0000_0005);
    queue_sample(32'h8000_0000);
    queue_sample(32'h7FFF_FFFF);

    // Writing the same length again still empties the ring.
    wait_all_results();
    apb_write(REG_WINDOW_LENGTH, 32'd3);
    check_window_readback();
    queue_sample(32'h0000_0007);
    queue_sample(32'h0000_0009);

    // Lengths above the ring size saturate; upper data bits are dropped.
    wait_all_results();
    apb_write(REG_WINDOW_LENGTH, 32'd511);
    check_window_readback();
    queue_sample(32'h8000_0000);
    queue_sample(32'h8000_0000);
    queue_sample(32'h0000_0003);
    wait_all_results();
    apb_write(REG_WINDOW_LENGTH, 32'hFFFF_FE02);
    check_window_readback();
    queue_sample(32'h0000_0001);
    queue_sample(32'hFFFF_FFFC);
    queue_sample(32'h0000_0002);

    // Full ring near positive full scale, wrapping, with one long output stall.
    run_phase(32'd256, 280, MIX_HIGH, 1'b1, 1'b1);
    hold_go <= 1'b1;
    // Saturated window near negative full scale, sender never idle.
    run_phase(32'd300, 270, MIX_LOW, 1'b0, 1'b1);

    // Random windows and sample patterns.
    random_items = 0;
    while (random_items < 430) begin
      case ($urandom_range(0, 9))
        0: win_word = 32'd1;
        1: win_word = 32'd2;
        2, 3: win_word = $urandom_range(3, 16);
        4, 5: win_word = $urandom_range(17, 255);
        6: win_word = 32'd256;
        7: win_word = 32'd0;
        8: win_word = $urandom_range(257, 511);
        default: win_word = $urandom_range(1, 8);
      endcase
      if ($urandom_range(0, 3) == 0) win_word |= $urandom() & 32'hFFFF_FE00;
      count = (win_word[8:0] > 16) ? $urandom_range(10, 80) : $urandom_range(5, 40);
      case ($urandom_range(0, 7))
        4: mix = MIX_EXTREME;
        5: mix = MIX_SMALLVAL;
        6: mix = MIX_HIGH;
        7: mix = MIX_LOW;
        default: mix = MIX_ANY;
      endcase
      run_phase(win_word, count, mix, $urandom_range(0, 2) != 0, $urandom_range(0, 2) != 0);
      random_items += count;
    end

    wait_all_results();
    repeat (60) @(posedge clk);
    if (averages_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", averages_due.size()));
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
